### design/tfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfb_pkg: shared types and constants for the temporal frame blender
// Field widths, configuration register indexes and divider sizing.
// ----------------------------------------------------------------------------
package tfb_pkg;

  // item field widths
  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int N_W        = 8;

  // row index is reduced modulo this before use
  localparam int MAX_ROWS   = 4096;

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;

  // reciprocal divider: dividend width, reciprocal scale and width
  localparam int DIV_W      = 16;
  localparam int REC_SHIFT  = 16;
  localparam int REC_W      = REC_SHIFT + 1;
  localparam int PROD_W     = DIV_W + REC_W;

  // three colour lanes plus one lane for the row modulo
  localparam int NUM_CHAN   = 3;
  localparam int LANES      = NUM_CHAN + 1;
  localparam int ROW_LANE   = NUM_CHAN;

  // reset value of the smoothing factor
  localparam logic [N_W-1:0] N_RESET = N_W'(1);

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SMOOTH = 1'b0,
    CFG_ILV    = 1'b1
  } cfg_idx_t;

  // one pixel: [2] red, [1] green, [0] blue
  typedef logic [NUM_CHAN-1:0][PIX_W-1:0] pix_t;

  // per-lane words through the divider
  typedef logic [LANES-1:0][DIV_W-1:0] lane_t;

endpackage

### design/temporal_frame_blend_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temporal_frame_blend_top: in-between frame pixel generator
// Blends or row-interleaves co-located pixels of two source frames.
// ----------------------------------------------------------------------------
// Usage
//   Item in : start with the A and B pixels, row and step. busy is always
//             low, so an item is taken on every cycle that start is high.
//   Result  : out_valid marks the in-between pixel for exactly one cycle.
//   Config  : cfg_we/cfg_addr/cfg_data; index 0 smoothing factor (0 reads
//             as 1), index 1 interleave enable. Write only while idle.
// Throughput and pipeline
//   One item per cycle. The valid bit passes through s1_v_r, s2_v_r,
//   s3_v_r and out_valid_r, which drives out_valid.
//   Pipeline: operand/product sums and reciprocal lookup, sum times
//   reciprocal, quotient times factor for the remainder, then one
//   correction step and output register. The quotient by the factor and
//   the row modulo both use the same reciprocal multiply.
// Reset
//   rst_n clears all valid bits and loads factor 1, blend mode.
// Back-pressure
//   None: the receiver must take each result in the cycle it is shown.
// ----------------------------------------------------------------------------
module temporal_frame_blend_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [tfb_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [tfb_pkg::CFG_DATA_W-1:0]   cfg_data,
  // item in
  input  logic                             start,
  output logic                             busy,
  input  logic [tfb_pkg::PIX_W-1:0]        in_red_a,
  input  logic [tfb_pkg::PIX_W-1:0]        in_green_a,
  input  logic [tfb_pkg::PIX_W-1:0]        in_blue_a,
  input  logic [tfb_pkg::PIX_W-1:0]        in_red_b,
  input  logic [tfb_pkg::PIX_W-1:0]        in_green_b,
  input  logic [tfb_pkg::PIX_W-1:0]        in_blue_b,
  input  logic [tfb_pkg::ROW_W-1:0]        in_row,
  input  logic [tfb_pkg::N_W-1:0]          in_step,
  // result out
  output logic                             out_valid,
  output logic [tfb_pkg::PIX_W-1:0]        out_red_out,
  output logic [tfb_pkg::PIX_W-1:0]        out_green_out,
  output logic [tfb_pkg::PIX_W-1:0]        out_blue_out
);

  localparam int PIX_W  = tfb_pkg::PIX_W;
  localparam int ROW_W  = tfb_pkg::ROW_W;
  localparam int N_W    = tfb_pkg::N_W;
  localparam int DIV_W  = tfb_pkg::DIV_W;
  localparam int REC_W  = tfb_pkg::REC_W;
  localparam int PROD_W = tfb_pkg::PROD_W;
  localparam int NCH    = tfb_pkg::NUM_CHAN;
  localparam int LANES  = tfb_pkg::LANES;
  localparam int RL     = tfb_pkg::ROW_LANE;

  // configuration registers
  logic [N_W-1:0] smooth_r, smooth_nxt;
  logic           ilv_r, ilv_nxt;

  always_comb begin
    smooth_nxt = smooth_r;
    ilv_nxt    = ilv_r;
    if (cfg_we) begin
      case (tfb_pkg::cfg_idx_t'(cfg_addr))
        tfb_pkg::CFG_SMOOTH: smooth_nxt = cfg_data[N_W-1:0];
        tfb_pkg::CFG_ILV:    ilv_nxt    = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= tfb_pkg::N_RESET;
      ilv_r    <= 1'b0;
    end else begin
      smooth_r <= smooth_nxt;
      ilv_r    <= ilv_nxt;
    end
  end

  // pipeline always advances
  assign busy = 1'b0;

  // reciprocal table: floor(2^REC_SHIFT / n), entry 0 as n = 1
  logic [REC_W-1:0] recip_tab [2**N_W];

  for (genvar gi = 0; gi < 2**N_W; gi++) begin : g_recip
    localparam int Div = (gi == 0) ? 1 : gi;
    localparam logic [REC_W-1:0] Rcp = REC_W'((1 << tfb_pkg::REC_SHIFT) / Div);
    assign recip_tab[gi] = Rcp;
  end

  // ---------------------------------------------------------------- stage 0
  logic [N_W-1:0]      n_eff, k_eff, n_minus_k;
  logic [ROW_W-1:0]    row_red;
  tfb_pkg::pix_t       pix_a, pix_b;
  tfb_pkg::lane_t      s1_x_nxt;
  logic                s1_v_nxt;

  assign pix_a = {in_red_a, in_green_a, in_blue_a};
  assign pix_b = {in_red_b, in_green_b, in_blue_b};

  // effective factor and clamped step, weighted sums, row as dividend
  always_comb begin
    n_eff     = (smooth_r == '0) ? N_W'(1) : smooth_r;
    k_eff     = (in_step >= n_eff) ? (n_eff - N_W'(1)) : in_step;
    n_minus_k = n_eff - k_eff;
    row_red   = ROW_W'(32'(in_row) % tfb_pkg::MAX_ROWS);
    for (int c = 0; c < NCH; c++) begin
      s1_x_nxt[c] = DIV_W'(pix_a[c]) * DIV_W'(n_minus_k)
                  + DIV_W'(pix_b[c]) * DIV_W'(k_eff);
    end
    s1_x_nxt[RL] = DIV_W'(row_red);
    s1_v_nxt     = start && !busy;
  end

  logic             s1_v_r;
  tfb_pkg::lane_t   s1_x_r;
  logic [REC_W-1:0] s1_rec_r;
  logic [N_W-1:0]   s1_n_r, s1_k_r;
  logic             s1_ilv_r;
  tfb_pkg::pix_t    s1_a_r, s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r   <= s1_x_nxt;
    s1_rec_r <= recip_tab[n_eff];
    s1_n_r   <= n_eff;
    s1_k_r   <= k_eff;
    s1_ilv_r <= ilv_r;
    s1_a_r   <= pix_a;
    s1_b_r   <= pix_b;
  end

  // ---------------------------------------------------------------- stage 1
  // quotient estimate: (x * recip) >> REC_SHIFT, low by at most one
  tfb_pkg::lane_t s2_q_nxt;
  logic [LANES-1:0][PROD_W-1:0] prod;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      prod[l]     = PROD_W'(s1_x_r[l]) * PROD_W'(s1_rec_r);
      s2_q_nxt[l] = prod[l][tfb_pkg::REC_SHIFT +: DIV_W];
    end
  end

  logic           s2_v_r;
  tfb_pkg::lane_t s2_q_r, s2_x_r;
  logic [N_W-1:0] s2_n_r, s2_k_r;
  logic           s2_ilv_r;
  tfb_pkg::pix_t  s2_a_r, s2_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_q_r   <= s2_q_nxt;
    s2_x_r   <= s1_x_r;
    s2_n_r   <= s1_n_r;
    s2_k_r   <= s1_k_r;
    s2_ilv_r <= s1_ilv_r;
    s2_a_r   <= s1_a_r;
    s2_b_r   <= s1_b_r;
  end

  // ---------------------------------------------------------------- stage 2
  // partial remainder x - q*n, below 2n; low bits suffice
  tfb_pkg::lane_t s3_rem_nxt;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      s3_rem_nxt[l] = s2_x_r[l] - DIV_W'(s2_q_r[l] * DIV_W'(s2_n_r));
    end
  end

  logic           s3_v_r;
  tfb_pkg::lane_t s3_q_r, s3_rem_r;
  logic [N_W-1:0] s3_n_r, s3_k_r;
  logic           s3_ilv_r;
  tfb_pkg::pix_t  s3_a_r, s3_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_q_r   <= s2_q_r;
    s3_rem_r <= s3_rem_nxt;
    s3_n_r   <= s2_n_r;
    s3_k_r   <= s2_k_r;
    s3_ilv_r <= s2_ilv_r;
    s3_a_r   <= s2_a_r;
    s3_b_r   <= s2_b_r;
  end

  // ---------------------------------------------------------------- stage 3
  // one correction step, then blend or interleave select
  logic [LANES-1:0] rem_ge;
  tfb_pkg::lane_t   q_fix, r_fix;
  logic             take_a;
  tfb_pkg::pix_t    out_pix_nxt;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_ge[l] = (s3_rem_r[l] >= DIV_W'(s3_n_r));
      q_fix[l]  = s3_q_r[l] + DIV_W'(rem_ge[l]);
      r_fix[l]  = s3_rem_r[l] - (rem_ge[l] ? DIV_W'(s3_n_r) : '0);
    end
    take_a = (r_fix[RL][N_W-1:0] >= s3_k_r);
    for (int c = 0; c < NCH; c++) begin
      if (s3_ilv_r) begin
        out_pix_nxt[c] = take_a ? s3_a_r[c] : s3_b_r[c];
      end else begin
        out_pix_nxt[c] = q_fix[c][PIX_W-1:0];
      end
    end
  end

  logic          out_valid_r;
  tfb_pkg::pix_t out_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_pix_r <= out_pix_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_pix_r[2];
  assign out_green_out = out_pix_r[1];
  assign out_blue_out  = out_pix_r[0];

  // ------------------------------------------------------------ assertions
  // blended channel lies between the two source values
  logic blend_ok;

  always_comb begin
    blend_ok = 1'b1;
    for (int c = 0; c < NCH; c++) begin
      if ((q_fix[c] < DIV_W'(s3_a_r[c]) && q_fix[c] < DIV_W'(s3_b_r[c])) ||
          (q_fix[c] > DIV_W'(s3_a_r[c]) && q_fix[c] > DIV_W'(s3_b_r[c]))) begin
        blend_ok = 1'b0;
      end
    end
  end

  a_valid_flow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> s2_v_r ##1 s3_v_r ##1 out_valid)
    else $error("item lost in pipeline");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !s3_v_r |=> !out_valid)
    else $error("result strobe without item");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> (s3_rem_r[0] < 2 * DIV_W'(s3_n_r)) && (s3_rem_r[RL] < 2 * DIV_W'(s3_n_r)))
    else $error("reciprocal estimate off by more than one");

  a_blend_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !s3_ilv_r |-> blend_ok)
    else $error("blend outside source range");

  a_step0_is_a: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && s3_ilv_r && (s3_k_r == '0) |-> take_a)
    else $error("interleave at step zero must take first frame");

endmodule

### bench/tb_temporal_frame_blend_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_temporal_frame_blend_top: self-checking bench for the frame blender
// Drives pixel pairs through the start/busy port and predicts each
// in-between pixel from a local copy of the smoothing factor and mode.
// Expected pixels are queued and compared field by field against every
// out_valid strobe. Directed corner cases come first, then randomised
// phases across many factor/mode settings with bursty traffic.
// ----------------------------------------------------------------------------
module tb_temporal_frame_blend_top;

  localparam int PIX_W      = tfb_pkg::PIX_W;
  localparam int ROW_W      = tfb_pkg::ROW_W;
  localparam int N_W        = tfb_pkg::N_W;
  localparam int CFG_ADDR_W = tfb_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = tfb_pkg::CFG_DATA_W;
  localparam int MAX_ROWS   = tfb_pkg::MAX_ROWS;

  localparam int DRAIN_CYCLES = 8;       // pipeline is four deep
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_CAP   = 40;
  localparam int RANDOM_PHASES = 16;
  localparam int PHASE_ITEMS  = 100;

  // one input item: both source pixels, row and sub-frame step
  typedef struct packed {
    logic [PIX_W-1:0] red_a;
    logic [PIX_W-1:0] green_a;
    logic [PIX_W-1:0] blue_a;
    logic [PIX_W-1:0] red_b;
    logic [PIX_W-1:0] green_b;
    logic [PIX_W-1:0] blue_b;
    logic [ROW_W-1:0] row;
    logic [N_W-1:0]   step;
  } pixel_pair_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  start;
  logic                  busy;
  logic [PIX_W-1:0]      in_red_a, in_green_a, in_blue_a;
  logic [PIX_W-1:0]      in_red_b, in_green_b, in_blue_b;
  logic [ROW_W-1:0]      in_row;
  logic [N_W-1:0]        in_step;
  logic                  out_valid;
  logic [PIX_W-1:0]      out_red_out, out_green_out, out_blue_out;

  // shadow of the configuration registers
  logic [N_W-1:0] cur_factor;
  logic           cur_interleave;

  rgb_t        blended_q[$];
  int unsigned pixels_sent;
  int unsigned pixels_checked;
  int unsigned mismatches;
  int unsigned strays;
  int unsigned settings_used;
  int unsigned cycle_count;

  temporal_frame_blend_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .in_red_a     (in_red_a),
    .in_green_a   (in_green_a),
    .in_blue_a    (in_blue_a),
    .in_red_b     (in_red_b),
    .in_green_b   (in_green_b),
    .in_blue_b    (in_blue_b),
    .in_row       (in_row),
    .in_step      (in_step),
    .out_valid    (out_valid),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // exact integer crossfade of one channel
  function automatic logic [PIX_W-1:0] crossfade(int unsigned a, int unsigned b,
                                                 int unsigned n, int unsigned k);
    int unsigned sum;
    sum = a * (n - k) + b * k;
    return PIX_W'(sum / n);
  endfunction

  function automatic rgb_t predict_pixel(pixel_pair_t p);
    int unsigned n;
    int unsigned k;
    int unsigned row_mod;
    logic        take_a;
    rgb_t        px;
    // a zero factor behaves as one; the step is clamped below the factor
    n = (cur_factor == '0) ? 1 : int'(cur_factor);
    k = (int'(p.step) >= n) ? n - 1 : int'(p.step);
    if (cur_interleave) begin
      row_mod  = int'(p.row) % MAX_ROWS;
      take_a   = (row_mod % n) >= k;
      px.red   = take_a ? p.red_a   : p.red_b;
      px.green = take_a ? p.green_a : p.green_b;
      px.blue  = take_a ? p.blue_a  : p.blue_b;
    end else begin
      px.red   = crossfade(p.red_a,   p.red_b,   n, k);
      px.green = crossfade(p.green_a, p.green_b, n, k);
      px.blue  = crossfade(p.blue_a,  p.blue_b,  n, k);
    end
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [PIX_W-1:0] expv,
                             logic [PIX_W-1:0] actv);
    if (actv !== expv) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                 $time, name, expv, actv);
    end
  endtask

  always @(posedge clk) begin : check_results
    rgb_t want;
    if (rst_n && out_valid) begin
      if (blended_q.size() == 0) begin
        strays++;
        if (strays <= REPORT_CAP)
          $display("%0t ns: unexpected pixel, expected none, actual %0d/%0d/%0d",
                   $time, out_red_out, out_green_out, out_blue_out);
      end else begin
        want = blended_q.pop_front();
        check_field("red_out",   want.red,   out_red_out);
        check_field("green_out", want.green, out_green_out);
        check_field("blue_out",  want.blue,  out_blue_out);
        pixels_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d pixels still due",
               cycle_count, blended_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // one item: held until taken, expectation queued at the accepting edge
  task automatic send_pixel(pixel_pair_t p);
    @(negedge clk);
    start      <= 1'b1;
    in_red_a   <= p.red_a;
    in_green_a <= p.green_a;
    in_blue_a  <= p.blue_a;
    in_red_b   <= p.red_b;
    in_green_b <= p.green_b;
    in_blue_b  <= p.blue_b;
    in_row     <= p.row;
    in_step    <= p.step;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    blended_q.push_back(predict_pixel(p));
    pixels_sent++;
  endtask

  task automatic pause_sender(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic write_reg(tfb_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      tfb_pkg::CFG_SMOOTH: cur_factor     = value[N_W-1:0];
      tfb_pkg::CFG_ILV:    cur_interleave = value[0];
      default: ;
    endcase
  endtask

  task automatic set_mode(int unsigned factor, logic interleave);
    write_reg(tfb_pkg::CFG_SMOOTH, CFG_DATA_W'(factor));
    write_reg(tfb_pkg::CFG_ILV, CFG_DATA_W'(interleave));
    settings_used++;
  endtask

  // all expected pixels in, then let the pipeline settle
  task automatic wait_drained();
    while (blended_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic pixel_pair_t make_pair(int unsigned ra, int unsigned ga,
                                            int unsigned ba, int unsigned rb,
                                            int unsigned gb, int unsigned bb,
                                            int unsigned r, int unsigned s);
    pixel_pair_t p;
    p.red_a   = PIX_W'(ra);
    p.green_a = PIX_W'(ga);
    p.blue_a  = PIX_W'(ba);
    p.red_b   = PIX_W'(rb);
    p.green_b = PIX_W'(gb);
    p.blue_b  = PIX_W'(bb);
    p.row     = ROW_W'(r);
    p.step    = N_W'(s);
    return p;
  endfunction

  // channel values lean on the rails now and then
  function automatic int unsigned rand_channel();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return (1 << PIX_W) - 1;
      default: return $urandom_range(0, (1 << PIX_W) - 1);
    endcase
  endfunction

  // mostly in-range steps, some at or beyond the factor
  function automatic pixel_pair_t random_pair();
    int unsigned n;
    int unsigned s;
    n = (cur_factor == '0) ? 1 : int'(cur_factor);
    if ($urandom_range(0, 4) != 0)
      s = $urandom_range(0, n - 1);
    else
      s = $urandom_range(0, (1 << N_W) - 1);
    return make_pair(rand_channel(), rand_channel(), rand_channel(),
                     rand_channel(), rand_channel(), rand_channel(),
                     $urandom_range(0, (1 << ROW_W) - 1), s);
  endfunction

  // bursts of random length with random gaps between them
  task automatic send_random_pixels(int unsigned count);
    int unsigned burst;
    burst = 0;
    repeat (count) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
      end
      send_pixel(random_pair());
      burst--;
    end
    pause_sender(1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // factor 1 out of reset: every step clamps to 0, output is frame A
  task automatic test_reset_defaults();
    send_pixel(make_pair(255, 255, 255, 0, 0, 0, 0, 0));
    send_pixel(make_pair(0, 0, 0, 255, 255, 255, 4095, 255));
    send_pixel(make_pair(18, 200, 77, 143, 9, 250, 1234, 7));
    pause_sender(1);
    wait_drained();
  endtask

  // crossfade at full-scale factor, zero factor and smallest split
  task automatic test_blend_corners();
    set_mode(255, 1'b0);
    send_pixel(make_pair(0, 0, 0, 255, 255, 255, 0, 0));
    send_pixel(make_pair(0, 0, 0, 255, 255, 255, 1, 254));
    send_pixel(make_pair(0, 128, 255, 255, 127, 0, 2, 127));
    send_pixel(make_pair(0, 0, 0, 255, 255, 255, 3, 255));
    send_pixel(make_pair(255, 255, 255, 255, 255, 255, 4095, 200));
    send_pixel(make_pair(255, 255, 255, 0, 0, 0, 5, 1));
    pause_sender(1);
    wait_drained();
    set_mode(0, 1'b0);
    send_pixel(make_pair(10, 20, 30, 200, 210, 220, 6, 3));
    pause_sender(1);
    wait_drained();
    set_mode(2, 1'b0);
    send_pixel(make_pair(1, 0, 255, 0, 1, 254, 7, 1));
    send_pixel(make_pair(255, 254, 3, 254, 255, 4, 8, 1));
    pause_sender(1);
    wait_drained();
  endtask

  // row selection around the factor, clamped steps, top row
  task automatic test_interleave_corners();
    set_mode(4, 1'b1);
    for (int r = 0; r < 6; r++)
      send_pixel(make_pair(170, 85, 15, 85, 170, 240, r, 2));
    send_pixel(make_pair(170, 85, 15, 85, 170, 240, 4095, 3));
    send_pixel(make_pair(170, 85, 15, 85, 170, 240, 2, 200));
    pause_sender(1);
    wait_drained();
    set_mode(255, 1'b1);
    send_pixel(make_pair(255, 0, 255, 0, 255, 0, 4095, 254));
    send_pixel(make_pair(255, 0, 255, 0, 255, 0, 254, 254));
    pause_sender(1);
    wait_drained();
    set_mode(1, 1'b1);
    send_pixel(make_pair(1, 2, 3, 4, 5, 6, 4095, 9));
    pause_sender(1);
    wait_drained();
  endtask

  // randomised traffic over fixed corner settings, then random ones
  task automatic test_random_phases();
    int unsigned corner_factor [8] = '{1, 255, 0, 2, 3, 254, 16, 100};
    int unsigned f;
    logic        ilv;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 8) begin
        f   = corner_factor[p];
        ilv = p[0];
      end else begin
        f   = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 255)
                                          : $urandom_range(1, 8);
        ilv = 1'($urandom_range(0, 1));
      end
      set_mode(f, ilv);
      send_random_pixels(PHASE_ITEMS);
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = '0;
    cfg_data       = '0;
    start          = 1'b0;
    in_red_a       = '0;
    in_green_a     = '0;
    in_blue_a      = '0;
    in_red_b       = '0;
    in_green_b     = '0;
    in_blue_b      = '0;
    in_row         = '0;
    in_step        = '0;
    cur_factor     = tfb_pkg::N_RESET;
    cur_interleave = 1'b0;
    pixels_sent    = 0;
    pixels_checked = 0;
    mismatches     = 0;
    strays         = 0;
    settings_used  = 0;
    cycle_count    = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_blend_corners();
    test_interleave_corners();
    test_random_phases();
    wait_drained();

    $display("Sent %0d pixel pairs, checked %0d blended pixels over %0d settings",
             pixels_sent, pixels_checked, settings_used);
    $display("Covered blend and row interleave, zero/unit/full-scale factors, clamped steps");
    if (mismatches == 0 && strays == 0 && blended_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
